FILE: sv/cap_pkg.sv
`default_nettype none
package cap_pkg;
    localparam int FRAMES    = 64;
    localparam int PAGE_BITS = 20;
    localparam int AGE_BITS  = 32;
    localparam int IDX_W     = $clog2(FRAMES);
    localparam int CNT_W     = $clog2(FRAMES + 1);
    localparam int WID_W     = 6;
    localparam int INT_W     = 7;
    localparam int CAP_W     = 7;

    localparam logic [1:0] CFG_REF_WIDTH      = 2'd0;
    localparam logic [1:0] CFG_SHIFT_INTERVAL = 2'd1;
    localparam logic [1:0] CFG_FRAMES_IN_USE  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_WALK,
        ST_DONE
    } state_t;

    // per-cycle command broadcast to every frame cell
    typedef struct packed {
        logic                 set_top;    // OR top bit into selected frame
        logic                 load;       // load selected frame with new page
        logic                 age_sel;    // shift selected frame right once
        logic                 age_all;    // shift all filled frames right once
        logic [IDX_W-1:0]     sel;
        logic [CNT_W-1:0]     filled;
        logic [AGE_BITS-1:0]  top;
        logic                 dirty;
        logic [PAGE_BITS-1:0] page;
    } cell_cmd_t;
endpackage
`default_nettype wire

FILE: sv/clock_aging_page_replacement_core.sv
// Clock (second chance) page replacement with aging reference registers.
// Input channel: page_number/dirty_ref, valid in_valid, stall in_stall.
// Output channel: hit, frame_index, replaced, evicted_page, write_back and
// the two saturating totals, valid out_valid, stall out_stall.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; written
// only while idle.
// One page reference is handled at a time. Lookup runs combinationally
// through the row of frame cells (a match chain), so a hit or a free-frame
// fill goes from the input transfer through the LOOK and DONE states to the
// result register, and the next reference is taken only from IDLE. A fault
// with all frames full goes through LOOK, walks the clock hand one frame a
// cycle in WALK until a victim is found, then goes through DONE. The hand
// walk is what sets the rate.
// The result is held in an output register; the next reference is taken
// as soon as that register is passed on, or while it is being passed on.
// A stalled result holds its value until transferred.
// Reset clears all frames' reference and dirty bits, counters, hand and
// totals; page tags need no clearing since only filled frames match.
`default_nettype none
module clock_aging_page_replacement_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [19:0] page_number,
    input  wire logic        dirty_ref,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             hit,
    output logic [5:0]       frame_index,
    output logic             replaced,
    output logic [19:0]      evicted_page,
    output logic             write_back,
    output logic [31:0]      fault_total,
    output logic [31:0]      write_back_total,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    localparam int F  = cap_pkg::FRAMES;
    localparam int IW = cap_pkg::IDX_W;
    localparam int CW = cap_pkg::CNT_W;
    localparam int RB = cap_pkg::AGE_BITS;
    localparam int PB = cap_pkg::PAGE_BITS;

    // configuration registers
    logic [cap_pkg::WID_W-1:0] ref_width_reg;
    logic [cap_pkg::INT_W-1:0] shift_interval_reg;
    logic [cap_pkg::CAP_W-1:0] frames_in_use_reg;

    // control state
    cap_pkg::state_t state_reg, state_next;
    logic [CW-1:0] filled_reg, filled_next;
    logic [IW-1:0] hand_reg, hand_next;
    logic [IW-1:0] start_reg, start_next;
    logic [cap_pkg::INT_W-1:0] refcnt_reg, refcnt_next;
    logic [31:0] faults_reg, faults_next;
    logic [31:0] wbs_reg, wbs_next;

    // captured reference
    logic [PB-1:0] page_reg;
    logic          dirty_reg;

    // result register
    logic          out_valid_reg, out_valid_next;
    logic          hit_reg, hit_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic          repl_reg, repl_next;
    logic [PB-1:0] evict_reg, evict_next;
    logic          wb_reg, wb_next;

    // effective configuration
    logic [5:0]    n_eff;
    logic [CW-1:0] cap_eff;
    logic [cap_pkg::INT_W-1:0] m_eff;
    logic [RB-1:0] top, mask;

    always_comb
    begin
        n_eff = ref_width_reg == '0 ? 6'd1 :
                (ref_width_reg > 6'(RB) ? 6'(RB) : ref_width_reg);
        cap_eff = frames_in_use_reg == '0 ? CW'(1) :
                  ({1'b0, frames_in_use_reg} > 8'(F) ? CW'(F) : CW'(frames_in_use_reg));
        m_eff = shift_interval_reg == '0 ? 7'd1 : shift_interval_reg;
        top   = RB'(1) << (n_eff - 6'd1);
        mask  = (top << 1) - RB'(1);
        if (n_eff == 6'(RB))
            mask = '1;
    end

    // frame cell row
    cap_pkg::cell_cmd_t cmd;
    logic          hit_chain [F+1];
    logic [IW-1:0] hidx_chain [F+1];
    logic [PB-1:0] cell_page [F];
    logic          cell_dirty [F];
    logic          cell_zero [F];

    assign hit_chain[0]  = 1'b0;
    assign hidx_chain[0] = '0;

    for (genvar g = 0; g < F; g++)
    begin : g_cell
        cap_frame_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .my_index    (IW'(g)),
            .cmd         (cmd),
            .look_page   (page_reg),
            .mask        (mask),
            .hit_in      (hit_chain[g]),
            .hit_idx_in  (hidx_chain[g]),
            .hit_out     (hit_chain[g+1]),
            .hit_idx_out (hidx_chain[g+1]),
            .page        (cell_page[g]),
            .dirty       (cell_dirty[g]),
            .zero_ref    (cell_zero[g])
        );
    end

    logic          out_take;
    logic          accept;
    logic [IW-1:0] hand_adv;
    logic [IW-1:0] hand_eff;
    logic          victim;
    logic [IW-1:0] vidx;

    assign out_take  = out_valid_reg && !out_stall;
    assign in_stall  = !(state_reg == cap_pkg::ST_IDLE && (!out_valid_reg || out_take));
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = state_reg == cap_pkg::ST_IDLE;

    always_comb
    begin
        hand_eff = {1'b0, hand_reg} >= filled_reg ? '0 : hand_reg;
        hand_adv = ({1'b0, hand_reg} + CW'(1) >= filled_reg) ? '0 : hand_reg + IW'(1);
    end

    always_comb
    begin
        state_next     = state_reg;
        filled_next    = filled_reg;
        hand_next      = hand_reg;
        start_next     = start_reg;
        refcnt_next    = refcnt_reg;
        faults_next    = faults_reg;
        wbs_next       = wbs_reg;
        out_valid_next = out_take ? 1'b0 : out_valid_reg;
        hit_next       = hit_reg;
        idx_next       = idx_reg;
        repl_next      = repl_reg;
        evict_next     = evict_reg;
        wb_next        = wb_reg;
        victim         = 1'b0;
        vidx           = hand_reg;
        cmd            = '0;
        cmd.sel        = hand_reg;
        cmd.filled     = filled_reg;
        cmd.top        = top;
        cmd.dirty      = dirty_reg;
        cmd.page       = page_reg;

        case (state_reg)
            cap_pkg::ST_IDLE:
            begin
                if (accept)
                    state_next = cap_pkg::ST_LOOK;
            end
            cap_pkg::ST_LOOK:
            begin
                hit_next   = hit_chain[F];
                repl_next  = 1'b0;
                evict_next = '0;
                wb_next    = 1'b0;
                if (hit_chain[F])
                begin
                    idx_next    = hidx_chain[F];
                    cmd.sel     = hidx_chain[F];
                    cmd.set_top = 1'b1;
                    state_next  = cap_pkg::ST_DONE;
                end
                else
                begin
                    faults_next = faults_reg == '1 ? faults_reg : faults_reg + 32'd1;
                    if (filled_reg < cap_eff)
                    begin
                        idx_next    = IW'(filled_reg);
                        cmd.sel     = IW'(filled_reg);
                        cmd.load    = 1'b1;
                        filled_next = filled_reg + CW'(1);
                        state_next  = cap_pkg::ST_DONE;
                    end
                    else
                    begin
                        hand_next  = hand_eff;
                        start_next = hand_eff;
                        state_next = cap_pkg::ST_WALK;
                    end
                end
            end
            cap_pkg::ST_WALK:
            begin
                if (cell_zero[hand_reg])
                begin
                    victim = 1'b1;
                    vidx   = hand_reg;
                end
                else if (hand_adv == start_reg)
                begin
                    cmd.age_sel = 1'b1;
                    victim      = 1'b1;
                    vidx        = hand_adv;
                end
                else
                begin
                    cmd.age_sel = 1'b1;
                    hand_next   = hand_adv;
                end
                if (victim && !cmd.age_sel)
                begin
                    // load now; ageing the same frame is not needed
                    cmd.sel  = vidx;
                    cmd.load = 1'b1;
                end
                if (victim)
                begin
                    idx_next   = vidx;
                    repl_next  = 1'b1;
                    evict_next = cell_page[vidx];
                    wb_next    = cell_dirty[vidx];
                    if (cell_dirty[vidx] && wbs_reg != '1)
                        wbs_next = wbs_reg + 32'd1;
                    // hand moves one past the victim
                    hand_next  = ({1'b0, vidx} + CW'(1) >= filled_reg) ? '0 : vidx + IW'(1);
                    start_next = vidx;
                    state_next = cap_pkg::ST_DONE;
                end
            end
            cap_pkg::ST_DONE:
            begin
                // full-circle victim is loaded here (after its ageing above)
                if (repl_reg && !cmd.load)
                begin
                    cmd.sel  = idx_reg;
                    cmd.load = 1'b1;
                end
                if (refcnt_reg + 7'd1 >= m_eff)
                begin
                    cmd.age_all = 1'b1;
                    refcnt_next = '0;
                end
                else
                    refcnt_next = refcnt_reg + 7'd1;
                out_valid_next = 1'b1;
                state_next     = cap_pkg::ST_IDLE;
            end
            default:
                state_next = cap_pkg::ST_IDLE;
        endcase
    end

    // A zero-ref victim is loaded during the walk and loaded again in DONE
    // with the same page, dirty bit and top bit, so the reload is harmless.
    // A full-circle victim is aged in its last walk cycle and only loaded
    // in DONE.

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= cap_pkg::ST_IDLE;
            filled_reg         <= '0;
            hand_reg           <= '0;
            start_reg          <= '0;
            refcnt_reg         <= '0;
            faults_reg         <= '0;
            wbs_reg            <= '0;
            out_valid_reg      <= 1'b0;
            ref_width_reg      <= 6'd8;
            shift_interval_reg <= 7'd10;
            frames_in_use_reg  <= 7'd50;
        end
        else
        begin
            state_reg     <= state_next;
            filled_reg    <= filled_next;
            hand_reg      <= hand_next;
            start_reg     <= start_next;
            refcnt_reg    <= refcnt_next;
            faults_reg    <= faults_next;
            wbs_reg       <= wbs_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    cap_pkg::CFG_REF_WIDTH:      ref_width_reg      <= cfg_data[5:0];
                    cap_pkg::CFG_SHIFT_INTERVAL: shift_interval_reg <= cfg_data[6:0];
                    cap_pkg::CFG_FRAMES_IN_USE:  frames_in_use_reg  <= cfg_data[6:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            page_reg  <= page_number;
            dirty_reg <= dirty_ref;
        end
        hit_reg   <= hit_next;
        idx_reg   <= idx_next;
        repl_reg  <= repl_next;
        evict_reg <= evict_next;
        wb_reg    <= wb_next;
    end

    assign out_valid        = out_valid_reg;
    assign hit              = hit_reg;
    assign frame_index      = idx_reg;
    assign replaced         = repl_reg;
    assign evicted_page     = evict_reg;
    assign write_back       = wb_reg;
    assign fault_total      = faults_reg;
    assign write_back_total = wbs_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        filled_reg <= CW'(F)) else $error("fill count beyond frames");
    a_walk_full: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == cap_pkg::ST_WALK |-> filled_reg != '0) else $error("walk with no frames");
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == cap_pkg::ST_LOOK) else $error("accept lost");
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && hit_reg |-> !repl_reg && !wb_reg) else $error("hit evicted");
endmodule
`default_nettype wire

FILE: sv/cap_frame_cell.sv
`default_nettype none
module cap_frame_cell (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [cap_pkg::IDX_W-1:0]     my_index,
    input  wire cap_pkg::cell_cmd_t            cmd,
    input  wire logic [cap_pkg::PAGE_BITS-1:0] look_page,
    input  wire logic [cap_pkg::AGE_BITS-1:0]  mask,
    input  wire logic                          hit_in,
    input  wire logic [cap_pkg::IDX_W-1:0]     hit_idx_in,
    output logic                               hit_out,
    output logic [cap_pkg::IDX_W-1:0]          hit_idx_out,
    output logic [cap_pkg::PAGE_BITS-1:0]      page,
    output logic                               dirty,
    output logic                               zero_ref
);
    logic [cap_pkg::PAGE_BITS-1:0] page_reg;
    logic                          dirty_reg;
    logic [cap_pkg::AGE_BITS-1:0]  ref_reg;
    logic                          filled;
    logic                          sel;
    logic                          match;

    assign filled = {1'b0, my_index} < cmd.filled;
    assign sel    = cmd.sel == my_index;
    assign match  = filled && page_reg == look_page;
    // lowest matching frame wins along the chain
    assign hit_out     = hit_in | match;
    assign hit_idx_out = hit_in ? hit_idx_in : my_index;
    assign page     = page_reg;
    assign dirty    = dirty_reg;
    assign zero_ref = (ref_reg & mask) == '0;

    always_ff @(posedge clk)
    begin
        if (cmd.load && sel)
            page_reg <= cmd.page;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dirty_reg <= 1'b0;
            ref_reg   <= '0;
        end
        else
        begin
            if (cmd.load && sel)
            begin
                dirty_reg <= cmd.dirty;
                ref_reg   <= cmd.age_all ? (cmd.top >> 1) : cmd.top;
            end
            else
            begin
                if (cmd.set_top && sel)
                    dirty_reg <= dirty_reg | cmd.dirty;
                if (cmd.set_top && sel)
                    ref_reg <= cmd.age_all && filled ? ((ref_reg | cmd.top) >> 1)
                                                     : (ref_reg | cmd.top);
                else if ((cmd.age_sel && sel) || (cmd.age_all && filled))
                    ref_reg <= ref_reg >> 1;
            end
        end
    end
endmodule
`default_nettype wire
